@@ sv/grid_first_fit_rect_allocator_unit_assert.svh @@
// Assertion macros for the grid first-fit rectangle allocator.
// Included by the top level; depends on nothing else.
`ifndef GRID_FIRST_FIT_RECT_ALLOCATOR_UNIT_ASSERT_SVH
`define GRID_FIRST_FIT_RECT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GFFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define GFFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/gffr_pkg.sv @@
// Shared constants, payload structs and internal control types for the
// grid first-fit rectangle allocator. No dependencies.
package gffr_pkg;

	localparam int GRID     = 256;
	localparam int PAD      = 2;
	localparam int HALF_PAD = PAD / 2;
	// column / row index width and count width (counts reach GRID itself)
	localparam int CW = $clog2(GRID);
	localparam int DW = $clog2(GRID + 1);
	// width of padded sizes and sums, wide enough for a 9-bit request plus padding
	localparam int SW = ((DW > 9) ? DW : 9) + 1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [8:0] rect_width;
		logic [8:0] rect_height;
	} cmd_t;

	typedef struct packed {
		logic       placed;
		logic [8:0] pos_x;
		logic [8:0] pos_y;
		logic [8:0] used_width;
		logic [8:0] used_height;
	} res_t;

	typedef struct packed {
		logic            start;
		logic [DW-1:0]   width;
		logic [GRID-1:0] vec;
	} scan_ctrl_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic          found;
		logic [CW-1:0] x;
	} scan_stat_t;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_READ    = 6'b000010,
		ST_SCAN    = 6'b000100,
		ST_MARK_RD = 6'b001000,
		ST_MARK_WR = 6'b010000,
		ST_RESP    = 6'b100000
	} state_t;

endpackage

@@ sv/gffr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Standalone, no package use.
module gffr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/gffr_run_scan.sv @@
// Column scan unit: walks a row-occupancy vector one column a cycle and
// reports the first run of free columns of the requested width. Uses gffr_pkg.
module gffr_run_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gffr_pkg::scan_ctrl_t  ctrl,
	output gffr_pkg::scan_stat_t  stat
);
	import gffr_pkg::*;

	logic            busy_q;
	logic            done_q;
	logic            found_q;
	logic [GRID-1:0] vec_q;
	logic [CW-1:0]   x_q;
	logic [DW-1:0]   run_q;
	logic [DW-1:0]   width_q;
	logic [CW-1:0]   pos_q;
	logic [DW-1:0]   run_n;
	logic            hit;
	logic            last_col;

	// a free column extends the run, an occupied one restarts it
	assign run_n    = vec_q[0] ? '0 : run_q + DW'(1);
	assign hit      = (run_n == width_q);
	assign last_col = (x_q == CW'(GRID - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q  <= 1'b1;
				found_q <= 1'b0;
			end else if (busy_q) begin
				if (hit) begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					found_q <= 1'b1;
				end else if (last_col) begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					found_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			vec_q   <= ctrl.vec;
			x_q     <= '0;
			run_q   <= '0;
			width_q <= ctrl.width;
		end else if (busy_q) begin
			vec_q <= vec_q >> 1;
			x_q   <= x_q + CW'(1);
			run_q <= run_n;
			// run ends at this column, so it started width-1 columns back
			if (hit) begin
				pos_q <= CW'(DW'(x_q) + DW'(1) - width_q);
			end
		end
	end

	assign stat.busy  = busy_q;
	assign stat.done  = done_q;
	assign stat.found = found_q;
	assign stat.x     = pos_q;

endmodule

@@ sv/grid_first_fit_rect_allocator_unit.sv @@
// First-fit rectangle allocator over a 256 x 256 occupancy bitmap held one row per word
// in a single RAM. One transaction is worked at a time. An allocation tries candidate
// rows in order; per row it reads as many RAM rows as the padded height (h + 2) into an
// OR accumulator, then the column scan unit walks up to 256 columns one a cycle to find
// the first free run as wide as the padded width. A hit then marks each covered row with
// a read-modify-write (a read state, then a write state) before the response is sent.
// Rows never written since reset or the last clear read as free through a per-row valid
// bit, so no clearing pass is needed.
// Depends on gffr_pkg, gffr_ram, gffr_run_scan and the assertion macro header.
`include "grid_first_fit_rect_allocator_unit_assert.svh"

module grid_first_fit_rect_allocator_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  gffr_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output gffr_pkg::res_t  res
);
	import gffr_pkg::*;

	state_t          state_q;
	logic [GRID-1:0] row_valid_q;
	logic [DW-1:0]   ext_w_q;
	logic [DW-1:0]   ext_h_q;
	logic [CW-1:0]   y_q;
	logic [DW-1:0]   issue_q;
	logic [DW-1:0]   mrow_q;
	logic            rd_v_s1;
	logic            res_valid_q;

	logic [SW-1:0]   pw_q;
	logic [SW-1:0]   ph_q;
	logic            empty_q;
	logic [DW-1:0]   rows_q;
	logic [DW-1:0]   sw_q;
	logic [CW-1:0]   y_last_q;
	logic [GRID-1:0] acc_q;
	logic [CW-1:0]   x0_q;
	logic            placed_q;
	logic [8:0]      px_q;
	logic [8:0]      py_q;
	logic            rv_s1;
	logic [CW-1:0]   addr_s1;
	res_t            res_q;

	logic [SW-1:0]   pw_in;
	logic [SW-1:0]   ph_in;
	logic            empty_in;
	logic            issue_more;
	logic            ram_re;
	logic [CW-1:0]   ram_raddr;
	logic            ram_we;
	logic [GRID-1:0] ram_wdata;
	logic [GRID-1:0] ram_rdata;
	logic [GRID-1:0] rd_row;
	logic [GRID-1:0] mask;
	logic [SW-1:0]   x_end;
	logic [SW-1:0]   y_end;
	scan_ctrl_t      scan_ctrl;
	scan_stat_t      scan_stat;
	logic            cmd_fire;
	logic            res_fail;
	logic            pos_zero;

	assign pw_in    = SW'(cmd.rect_width) + SW'(PAD);
	assign ph_in    = SW'(cmd.rect_height) + SW'(PAD);
	assign empty_in = (pw_in == '0) || (ph_in == '0);

	assign cmd_stall  = (state_q != ST_IDLE);
	assign issue_more = (issue_q != rows_q);

	// unwritten rows read as free
	assign rd_row = rv_s1 ? ram_rdata : '0;

	always_comb begin
		for (int i = 0; i < GRID; i++) begin
			mask[i] = (SW'(i) >= SW'(x0_q)) && (SW'(i) < SW'(x0_q) + pw_q);
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = y_q + CW'(issue_q);
		unique case (state_q)
			ST_READ:    ram_re = issue_more;
			ST_MARK_RD: begin
				ram_re    = 1'b1;
				ram_raddr = y_q + CW'(mrow_q);
			end
			default:    ram_re = 1'b0;
		endcase
	end

	// the FSM keeps the read and the write-back of a marked row in separate cycles
	assign ram_we    = (state_q == ST_MARK_WR);
	assign ram_wdata = rd_row | mask;

	assign scan_ctrl.start = (state_q == ST_READ) && !issue_more && !rd_v_s1;
	assign scan_ctrl.width = sw_q;
	assign scan_ctrl.vec   = acc_q;

	assign x_end = SW'(scan_stat.x) + pw_q;
	assign y_end = SW'(y_q) + ph_q;

	gffr_ram #(
		.WIDTH(GRID),
		.DEPTH(GRID)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	gffr_run_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (scan_ctrl),
		.stat  (scan_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
			ext_w_q     <= '0;
			ext_h_q     <= '0;
			y_q         <= '0;
			issue_q     <= '0;
			mrow_q      <= '0;
			rd_v_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_READ) && issue_more;
			if (res_valid_q && !res_stall && state_q != ST_RESP) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						y_q     <= '0;
						issue_q <= '0;
						if (cmd.opcode == OP_CLEAR) begin
							row_valid_q <= '0;
							ext_w_q     <= '0;
							ext_h_q     <= '0;
							state_q     <= ST_RESP;
						end else if (pw_in > SW'(GRID) || ph_in > SW'(GRID)) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (issue_more) begin
						issue_q <= issue_q + DW'(1);
					end
					if (scan_ctrl.start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_stat.done) begin
						if (scan_stat.found) begin
							mrow_q <= '0;
							if (empty_q) begin
								state_q <= ST_RESP;
							end else begin
								if (x_end > SW'(ext_w_q)) begin
									ext_w_q <= DW'(x_end);
								end
								if (y_end > SW'(ext_h_q)) begin
									ext_h_q <= DW'(y_end);
								end
								state_q <= ST_MARK_RD;
							end
						end else if (y_q == y_last_q) begin
							state_q <= ST_RESP;
						end else begin
							// advance to the next candidate row
							y_q     <= y_q + CW'(1);
							issue_q <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_MARK_RD: begin
					state_q <= ST_MARK_WR;
				end
				ST_MARK_WR: begin
					row_valid_q[addr_s1] <= 1'b1;
					mrow_q               <= mrow_q + DW'(1);
					if (SW'(mrow_q) + SW'(1) == ph_q) begin
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_MARK_RD;
					end
				end
				ST_RESP: begin
					// hold until the output register is free
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rv_s1   <= row_valid_q[ram_raddr];
		addr_s1 <= ram_raddr;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					pw_q     <= pw_in;
					ph_q     <= ph_in;
					empty_q  <= empty_in;
					rows_q   <= empty_in ? DW'(1) : DW'(ph_in);
					sw_q     <= empty_in ? DW'(1) : DW'(pw_in);
					y_last_q <= (ph_in == '0) ? CW'(GRID - 1) : CW'(SW'(GRID) - ph_in);
					acc_q    <= '0;
					placed_q <= 1'b0;
					px_q     <= '0;
					py_q     <= '0;
				end
			end
			ST_READ: begin
				if (rd_v_s1) begin
					acc_q <= acc_q | rd_row;
				end
			end
			ST_SCAN: begin
				if (scan_stat.done) begin
					if (scan_stat.found) begin
						x0_q     <= scan_stat.x;
						placed_q <= 1'b1;
						px_q     <= 9'(SW'(scan_stat.x) + SW'(HALF_PAD));
						py_q     <= 9'(SW'(y_q) + SW'(HALF_PAD));
					end else begin
						acc_q <= '0;
					end
				end
			end
			ST_RESP: begin
				if (!res_valid_q || !res_stall) begin
					res_q.placed      <= placed_q;
					res_q.pos_x       <= px_q;
					res_q.pos_y       <= py_q;
					res_q.used_width  <= 9'(ext_w_q);
					res_q.used_height <= 9'(ext_h_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign cmd_fire = cmd_valid && !cmd_stall;
	assign res_fail = res_valid && !res.placed;
	assign pos_zero = (res.pos_x == '0) && (res.pos_y == '0);

	`GFFR_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, cmd_fire, cmd_stall, "overlapping transaction")
	`GFFR_ASSERT_NOW(a_fail_pos_zero, clk, arst_n, res_fail, pos_zero, "position on failure")
	`GFFR_ASSERT_NOW(a_mark_in_rect, clk, arst_n, ram_we, SW'(mrow_q) < ph_q, "mark past height")
	`GFFR_ASSERT_NOW(a_scan_idle_start, clk, arst_n, scan_ctrl.start, !scan_stat.busy, "scan busy")

endmodule

@@ sim/tb_grid_first_fit_rect_allocator_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for grid_first_fit_rect_allocator_unit: a scoreboard class
// predicts each result from its own copy of the occupancy grid and extents.
// Depends on gffr_pkg and the allocator RTL.

module tb_grid_first_fit_rect_allocator_unit;
	import gffr_pkg::*;

	// watchdog: longest stretch with no command or result accepted before the test gives up
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int DRAIN_CYCLES   = 50;
	localparam int RANDOM_ITEMS   = 100;

	logic clk;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	class alloc_scoreboard;
		bit   occ [GRID][GRID];
		int   sums [GRID+1][GRID+1];
		int   ext_w;
		int   ext_h;
		res_t expected_q [$];
		int   errors;

		function new();
			errors = 0;
			clear_grid();
		endfunction

		function void clear_grid();
			foreach (occ[y, x])
				occ[y][x] = 1'b0;
			ext_w = 0;
			ext_h = 0;
		endfunction

		// first-fit placement over a summed-area table of the grid
		function void note_command(cmd_t c);
			res_t r;
			int   pw, ph, px, py, area;
			bit   found;
			r = '0;
			if (c.opcode == OP_CLEAR) begin
				clear_grid();
				expected_q.push_back(r);
				return;
			end
			pw = int'(c.rect_width) + PAD;
			ph = int'(c.rect_height) + PAD;
			found = 1'b0;
			px = 0;
			py = 0;
			if (pw <= GRID && ph <= GRID) begin
				for (int x = 0; x <= GRID; x++)
					sums[0][x] = 0;
				for (int y = 0; y < GRID; y++) begin
					sums[y+1][0] = 0;
					for (int x = 0; x < GRID; x++)
						sums[y+1][x+1] = int'(occ[y][x]) + sums[y][x+1] + sums[y+1][x]
							- sums[y][x];
				end
				for (int y = 0; y < GRID && y + ph <= GRID && !found; y++) begin
					for (int x = 0; x < GRID && x + pw <= GRID && !found; x++) begin
						area = sums[y+ph][x+pw] - sums[y][x+pw] - sums[y+ph][x] + sums[y][x];
						if (!occ[y][x] && area == 0) begin
							found = 1'b1;
							px = x;
							py = y;
						end
					end
				end
			end
			if (found) begin
				for (int cy = 0; cy < ph; cy++)
					for (int cx = 0; cx < pw; cx++)
						occ[py+cy][px+cx] = 1'b1;
				if (pw > 0 && ph > 0) begin
					if (px + pw > ext_w)
						ext_w = px + pw;
					if (py + ph > ext_h)
						ext_h = py + ph;
				end
				r.placed = 1'b1;
				r.pos_x  = 9'(px + HALF_PAD);
				r.pos_y  = 9'(py + HALF_PAD);
			end
			r.used_width  = 9'(ext_w);
			r.used_height = 9'(ext_h);
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_result(res_t r);
			res_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("result %h with no transaction outstanding", r));
				return;
			end
			e = expected_q.pop_front();
			if (r.placed !== e.placed)
				report($sformatf("placed got %0d want %0d", r.placed, e.placed));
			if (r.pos_x !== e.pos_x)
				report($sformatf("pos_x got %0d want %0d", r.pos_x, e.pos_x));
			if (r.pos_y !== e.pos_y)
				report($sformatf("pos_y got %0d want %0d", r.pos_y, e.pos_y));
			if (r.used_width !== e.used_width)
				report($sformatf("used_width got %0d want %0d", r.used_width, e.used_width));
			if (r.used_height !== e.used_height)
				report($sformatf("used_height got %0d want %0d", r.used_height, e.used_height));
		endtask
	endclass

	alloc_scoreboard sb;
	int idle_cycles = 0;
	int burst_left  = 0;
	int stall_mode  = 0;
	int stall_left  = 0;

	grid_first_fit_rect_allocator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				sb.note_command(cmd);
			if (res_valid && !res_stall)
				sb.check_result(res);
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: free-running, lightly stalled or heavily stalled, in stretches
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(16, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: begin
				res_stall <= 1'b0;
			end
			1: begin
				res_stall <= ($urandom_range(0, 2) == 0);
			end
			default: begin
				res_stall <= ($urandom_range(0, 3) != 0);
			end
		endcase
	end

	function automatic cmd_t make_cmd(logic op, logic [8:0] w, logic [8:0] h);
		cmd_t c;
		c.opcode      = op;
		c.rect_width  = w;
		c.rect_height = h;
		return c;
	endfunction

	// mostly small rectangles so the grid stays shallow; clears keep fill low
	function automatic cmd_t random_cmd();
		cmd_t c;
		int   pick;
		pick = $urandom_range(0, 99);
		c.opcode      = OP_ALLOC;
		c.rect_width  = 9'($urandom_range(0, 12));
		c.rect_height = 9'($urandom_range(0, 12));
		if (pick < 12) begin
			c.opcode      = OP_CLEAR;
			c.rect_width  = 9'($urandom_range(0, 511));
			c.rect_height = 9'($urandom_range(0, 511));
		end else if (pick < 18) begin
			c.rect_width  = 9'($urandom_range(0, 511));
			c.rect_height = 9'($urandom_range(0, 511));
		end else if (pick < 32) begin
			c.rect_width  = 9'($urandom_range(0, 63));
			c.rect_height = 9'($urandom_range(0, 63));
		end
		return c;
	endfunction

	task automatic send_cmd(cmd_t c);
		@(negedge clk);
		cmd       <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(cmd_valid && !cmd_stall));
	endtask

	// drop valid for a random gap at the end of each burst
	task automatic issue(cmd_t c);
		send_cmd(c);
		if (burst_left == 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			cmd       <= make_cmd(1'($urandom), 9'($urandom), 9'($urandom));
			repeat ($urandom_range(0, 11))
				@(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 5);
		end else begin
			burst_left--;
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty rectangle pads to 2 x 2, then oversized and full-span requests
		issue(make_cmd(OP_ALLOC, 9'd0, 9'd0));
		issue(make_cmd(OP_ALLOC, 9'h1FF, 9'h1FF));
		issue(make_cmd(OP_ALLOC, 9'd256, 9'd0));
		issue(make_cmd(OP_ALLOC, 9'd0, 9'd256));
		issue(make_cmd(OP_ALLOC, 9'd254, 9'd0));
		issue(make_cmd(OP_ALLOC, 9'd0, 9'd254));
		issue(make_cmd(OP_ALLOC, 9'd253, 9'd253));
		issue(make_cmd(OP_CLEAR, 9'h1FF, 9'h1FF));
		issue(make_cmd(OP_CLEAR, 9'd0, 9'd0));
		// fill the whole grid, then a request that cannot fit
		issue(make_cmd(OP_ALLOC, 9'd254, 9'd254));
		issue(make_cmd(OP_ALLOC, 9'd0, 9'd253));
		issue(make_cmd(OP_ALLOC, 9'd1, 9'd1));
		issue(make_cmd(OP_CLEAR, 9'h0AA, 9'h155));
		issue(make_cmd(OP_ALLOC, 9'h0AA, 9'h055));
		issue(make_cmd(OP_ALLOC, 9'h055, 9'h0AA));
		issue(make_cmd(OP_ALLOC, 9'h055, 9'h055));
		issue(make_cmd(OP_ALLOC, 9'd1, 9'd1));
		issue(make_cmd(OP_CLEAR, 9'd0, 9'd0));

		repeat (RANDOM_ITEMS)
			issue(random_cmd());

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/gffr_pkg.sv
sv/gffr_ram.sv
sv/gffr_run_scan.sv
sv/grid_first_fit_rect_allocator_unit.sv
sim/tb_grid_first_fit_rect_allocator_unit.sv
